// File: rtl/core/assert_macros.svh
// Concurrent assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TSR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TSR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/tsr_pkg.sv
package tsr_pkg;

    localparam int FIELD_W    = 7;
    localparam int NUM_FIELDS = 5;
    localparam int STAMP_W    = FIELD_W * NUM_FIELDS;
    localparam int INDEX_W    = 10;
    localparam int CFG_ADDR_W = 1;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 24;

    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [INDEX_W-1:0] index_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_QUERY_START = 1'b0,
        REG_QUERY_END   = 1'b1
    } cfg_reg_t;

endpackage

// File: rtl/core/timestamp_range_record_search_top.sv
// Timestamp range record search.
// Input stream: one log record per transaction. s_tdata carries the decoded
// year, month, day, hour and minute (7 bits each, year lowest), s_tuser the
// blank flag and s_tlast marks the final record of a scan. The record at
// position NUM_RECORDS-1 also closes the scan.
// Output stream: one transaction per scan, after its final record, with the
// start and end record indexes and their found flags.
// The query bounds are set through cfg_wr_en/cfg_addr/cfg_wdata between
// scans; a zero bound takes the stamp of record 0 instead.
// Timing: a record is registered on acceptance and folded into the running
// best start and end from the input register; folding the final record
// loads the result register, which drives m_tvalid. One record per cycle is
// taken, set by the single compare-and-update stage, except as follows.
// When the result waits on m_tready, records that do not close a scan keep
// flowing; a closing record holds in the input register until the result
// register frees. Reset (aresetn low, synchronous) clears the bounds, the
// scan state and both valid flags.
`include "assert_macros.svh"

module timestamp_range_record_search_top #(
    parameter int NUM_RECORDS = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tsr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [tsr_pkg::STAMP_W-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // rec_year, rec_month, rec_day, rec_hour, rec_minute, zero pad
    input  logic [tsr_pkg::S_DATA_W-1:0]        s_tdata,
    // record_blank
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // start found, start record position, end found, end record position, zero pad
    output logic [tsr_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int POS_W = (NUM_RECORDS > 2) ? $clog2(NUM_RECORDS) : 1;
    localparam int EXT_W = (POS_W > tsr_pkg::INDEX_W) ? POS_W : tsr_pkg::INDEX_W;
    localparam int FW    = tsr_pkg::FIELD_W;

    logic [tsr_pkg::STAMP_W-1:0] query_start_reg;
    logic [tsr_pkg::STAMP_W-1:0] query_end_reg;

    logic                        in_valid_reg;
    logic                        in_blank_reg;
    logic                        in_last_reg;
    tsr_pkg::stamp_t             in_stamp_reg;

    logic [POS_W-1:0]            pos_reg, pos_next;
    tsr_pkg::stamp_t             first_stamp_reg, first_stamp_next;
    tsr_pkg::stamp_t             best_start_reg, best_start_next;
    tsr_pkg::stamp_t             best_end_reg, best_end_next;
    logic [POS_W-1:0]            start_pos_reg, start_pos_next;
    logic [POS_W-1:0]            end_pos_reg, end_pos_next;
    logic                        start_valid_reg, start_valid_next;
    logic                        end_valid_reg, end_valid_next;

    logic                        out_valid_reg;
    logic                        out_start_found_reg;
    tsr_pkg::index_t             out_start_idx_reg;
    logic                        out_end_found_reg;
    tsr_pkg::index_t             out_end_idx_reg;

    tsr_pkg::stamp_t             s_stamp;
    tsr_pkg::stamp_t             first_eff;
    logic                        closing;
    logic                        advance;
    logic                        take_start;
    logic                        take_end;
    logic [EXT_W-1:0]            start_ext;
    logic [EXT_W-1:0]            end_ext;

    assign s_stamp = {s_tdata[FW-1:0], s_tdata[2*FW-1:FW], s_tdata[3*FW-1:2*FW],
                      s_tdata[4*FW-1:3*FW], s_tdata[5*FW-1:4*FW]};

    assign closing  = in_last_reg || (pos_reg >= POS_W'(NUM_RECORDS - 1));
    assign advance  = in_valid_reg && (!closing || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_start_reg <= '0;
            query_end_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (tsr_pkg::cfg_reg_t'(cfg_addr))
                tsr_pkg::REG_QUERY_START: query_start_reg <= cfg_wdata;
                tsr_pkg::REG_QUERY_END:   query_end_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_blank_reg <= s_tuser;
            in_last_reg  <= s_tlast;
            in_stamp_reg <= s_stamp;
        end
    end

    always_comb begin
        first_eff = (pos_reg == '0) ? in_stamp_reg : first_stamp_reg;

        if (query_start_reg == '0) begin
            take_start = in_stamp_reg <= first_eff;
        end else begin
            take_start = (in_stamp_reg >= query_start_reg) &&
                         (!start_valid_reg || in_stamp_reg < best_start_reg);
        end

        if (query_end_reg == '0) begin
            take_end = in_stamp_reg >= first_eff;
        end else begin
            take_end = (in_stamp_reg <= query_end_reg) &&
                       (!end_valid_reg || best_end_reg == '0 ||
                        in_stamp_reg > best_end_reg);
        end
        take_start = take_start && !in_blank_reg;
        take_end   = take_end && !in_blank_reg;

        first_stamp_next = first_eff;
        best_start_next  = take_start ? in_stamp_reg : best_start_reg;
        start_pos_next   = take_start ? pos_reg : start_pos_reg;
        start_valid_next = start_valid_reg || take_start;
        best_end_next    = take_end ? in_stamp_reg : best_end_reg;
        end_pos_next     = take_end ? pos_reg : end_pos_reg;
        end_valid_next   = end_valid_reg || take_end;
        pos_next         = pos_reg + POS_W'(1);

        start_ext = start_valid_next ? EXT_W'(start_pos_next) : '0;
        end_ext   = end_valid_next ? EXT_W'(end_pos_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            first_stamp_reg <= '0;
            best_start_reg  <= '0;
            best_end_reg    <= '0;
            start_pos_reg   <= '0;
            end_pos_reg     <= '0;
            start_valid_reg <= 1'b0;
            end_valid_reg   <= 1'b0;
        end else if (advance) begin
            if (closing) begin
                pos_reg         <= '0;
                first_stamp_reg <= '0;
                best_start_reg  <= '0;
                best_end_reg    <= '0;
                start_pos_reg   <= '0;
                end_pos_reg     <= '0;
                start_valid_reg <= 1'b0;
                end_valid_reg   <= 1'b0;
            end else begin
                pos_reg         <= pos_next;
                first_stamp_reg <= first_stamp_next;
                best_start_reg  <= best_start_next;
                best_end_reg    <= best_end_next;
                start_pos_reg   <= start_pos_next;
                end_pos_reg     <= end_pos_next;
                start_valid_reg <= start_valid_next;
                end_valid_reg   <= end_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && closing) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && closing) begin
            out_start_found_reg <= start_valid_next;
            out_start_idx_reg   <= start_ext[tsr_pkg::INDEX_W-1:0];
            out_end_found_reg   <= end_valid_next;
            out_end_idx_reg     <= end_ext[tsr_pkg::INDEX_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_end_idx_reg, out_end_found_reg,
                       out_start_idx_reg, out_start_found_reg};

    `TSR_ASSERT_IMPL(a_result_from_close, aclk, aresetn, $rose(out_valid_reg),
        $past(advance && closing), "result without a closing record")
    `TSR_ASSERT_NEXT(a_scan_restart, aclk, aresetn, advance && closing,
        pos_reg == '0 && !start_valid_reg && !end_valid_reg, "scan state not cleared after result")
    `TSR_ASSERT_IMPL(a_no_close_overrun, aclk, aresetn,
        in_valid_reg && closing && out_valid_reg && !m_tready, !advance,
        "closing record overwrote pending result")

endmodule
